// File: src/ihp_pkg.sv
// Shared types, codes and constants for the IPv4 TCP/UDP header parser.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps

package ihp_pkg;

   // Default saturation point of the captured length
   localparam int IHP_MAX_FRAME = 65536;

   // Link types
   localparam logic [1:0] LINK_ETH  = 2'd0;
   localparam logic [1:0] LINK_NULL = 2'd1;
   localparam logic [1:0] LINK_RAW  = 2'd2;
   localparam logic [1:0] LINK_NONE = 2'd3;

   // Verdict codes
   localparam logic [2:0] VERDICT_TCP       = 3'd0;
   localparam logic [2:0] VERDICT_UDP       = 3'd1;
   localparam logic [2:0] VERDICT_TRUNC     = 3'd2;
   localparam logic [2:0] VERDICT_NOT_IPV4  = 3'd3;
   localparam logic [2:0] VERDICT_BAD_IP    = 3'd4;
   localparam logic [2:0] VERDICT_BAD_TCP   = 3'd5;
   localparam logic [2:0] VERDICT_EMPTY     = 3'd6;
   localparam logic [2:0] VERDICT_OTHER     = 3'd7;

   // Header constants
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0]  ETH_HDR_LEN    = 4'd14;
   localparam logic [3:0]  NULL_HDR_LEN   = 4'd4;
   localparam logic [3:0]  RAW_HDR_LEN    = 4'd0;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam int          IP_MIN_HDR     = 20;
   localparam int          TCP_MIN_HDR    = 20;
   localparam int          UDP_HDR_LEN    = 8;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   // Byte offsets within the IP header and transport header
   localparam int IP_OFS_PROTO   = 9;
   localparam int IP_OFS_SRC_LO  = 12;
   localparam int IP_OFS_SRC_HI  = 15;
   localparam int IP_OFS_DST_LO  = 16;
   localparam int IP_OFS_DST_HI  = 19;
   localparam int ETH_OFS_TYPE_0 = 12;
   localparam int ETH_OFS_TYPE_1 = 13;
   localparam int L4_OFS_SPORT   = 1;
   localparam int L4_OFS_DPORT   = 3;
   localparam int L4_OFS_ULEN    = 5;
   localparam int L4_OFS_TCPOFF  = 12;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  payload_offset;
      logic [15:0] payload_length;
   } rsp_data_type;

   // Start of the IP header for a link type
   function automatic logic [3:0] ip_base(input logic [1:0] lt);
      logic [3:0] b;
      case (lt)
         LINK_ETH:  b = ETH_HDR_LEN;
         LINK_NULL: b = NULL_HDR_LEN;
         default:   b = RAW_HDR_LEN;
      endcase
      return b;
   endfunction

endpackage

// File: src/ihp_if.sv
// Valid/ready channel interfaces of the IPv4 TCP/UDP header parser:
// request (frame bytes), response (verdict record) and register write.
`timescale 1ns / 1ps

interface ihp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [7:0]  protocol;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [7:0]  payload_offset;
   logic [15:0] payload_length;

   modport source (output valid, output verdict, output protocol, output src_ip,
                   output dst_ip, output src_port, output dst_port,
                   output payload_offset, output payload_length, input ready);
   modport sink   (input valid, input verdict, input protocol, input src_ip,
                   input dst_ip, input src_port, input dst_port,
                   input payload_offset, input payload_length, output ready);
endinterface

interface ihp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] link_type;

   modport source (output valid, output link_type, input ready);
   modport sink   (input valid, input link_type, output ready);
endinterface

// File: src/ipv4_tcp_udp_header_parser.sv
// Top level of the IPv4 TCP/UDP header parser.
// Depends on ihp_pkg (codes, constants, result record) and ihp_if.sv (channels).
`timescale 1ns / 1ps

// The parser takes a captured frame one byte per request, with last_byte set on
// the final byte, and returns one response per frame carrying the verdict, the
// IPv4 protocol and addresses, the transport ports and the payload window. Each
// request only advances the frame position and captures header fields; the
// verdict for a frame is formed in the same cycle as its last byte and
// registered. Requests are taken back to back; a two-entry output stage
// (result register plus skid register) lets the next frame stream in while a
// verdict waits for the sink, and req ready drops only when both entries are
// held. The captured length counts bytes and saturates at MAX_FRAME; bytes
// beyond it are dropped. link_type is written through the csr channel, which
// is always ready; write it only between frames. Link type 3 rejects every
// frame with verdict 7 and all other fields zero.
module ipv4_tcp_udp_header_parser #(
   parameter int MAX_FRAME = ihp_pkg::IHP_MAX_FRAME
) (
   input logic         clock,
   input logic         reset,
   ihp_req_if.sink     req_chan,
   ihp_rsp_if.source   rsp_chan,
   ihp_csr_if.sink     csr_chan
);
   import ihp_pkg::*;

   // Position counter holds 0..MAX_FRAME; arithmetic width also covers 16-bit fields
   localparam int PW = $clog2(MAX_FRAME + 1);
   localparam int CW = ((PW > 16) ? PW : 16) + 1;
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_FRAME);

   // Per-frame state
   logic [PW-1:0] pos_ff,   pos_in;
   logic [15:0]   etype_ff, etype_in;
   logic [7:0]    vihl_ff,  vihl_in;
   logic [7:0]    proto_ff, proto_in;
   logic [31:0]   sip_ff,   sip_in;
   logic [31:0]   dip_ff,   dip_in;
   logic [15:0]   sport_ff, sport_in;
   logic [15:0]   dport_ff, dport_in;
   logic [15:0]   ulen_ff,  ulen_in;
   logic [7:0]    toff_ff,  toff_in;
   logic [1:0]    link_ff;

   // Output stage
   rsp_data_type  out_ff, skid_ff, rsp_in;
   logic          out_vld_ff, skid_vld_ff;

   logic          req_fire, push, pop;
   logic          in_range;
   logic [3:0]    base;
   logic [CW-1:0] idx, base_w, r, s, ihl_w;
   logic [5:0]    ihl_upd, ihl_n, doff;
   logic [CW-1:0] caplen, t, poff, plen, dl, ulen_w;
   logic          show_ip, show_ports;

   assign req_fire      = req_chan.valid & req_chan.ready;
   assign push          = req_fire & req_chan.last_byte;
   assign pop           = out_vld_ff & rsp_chan.ready;
   assign req_chan.ready = ~skid_vld_ff;
   assign csr_chan.ready = 1'b1;

   // Field capture: place the byte by its position and the current link type
   always_comb begin
      in_range = pos_ff < MAX_POS;
      base     = ip_base(link_ff);
      idx      = CW'(pos_ff);
      base_w   = CW'(base);
      r        = idx - base_w;
      pos_in   = in_range ? (pos_ff + PW'(1)) : pos_ff;
      etype_in = etype_ff;
      vihl_in  = vihl_ff;
      proto_in = proto_ff;
      sip_in   = sip_ff;
      dip_in   = dip_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      ulen_in  = ulen_ff;
      toff_in  = toff_ff;
      ihl_upd  = 6'd0;
      ihl_w    = '0;
      s        = '0;
      if (in_range) begin
         if (link_ff == LINK_ETH &&
             (idx == CW'(ETH_OFS_TYPE_0) || idx == CW'(ETH_OFS_TYPE_1))) begin
            etype_in = {etype_ff[7:0], req_chan.data_byte};
         end
         if (idx >= base_w) begin
            if (r == '0) begin
               vihl_in = req_chan.data_byte;
            end else if (r == CW'(IP_OFS_PROTO)) begin
               proto_in = req_chan.data_byte;
            end else if (r >= CW'(IP_OFS_SRC_LO) && r <= CW'(IP_OFS_SRC_HI)) begin
               sip_in = {sip_ff[23:0], req_chan.data_byte};
            end else if (r >= CW'(IP_OFS_DST_LO) && r <= CW'(IP_OFS_DST_HI)) begin
               dip_in = {dip_ff[23:0], req_chan.data_byte};
            end
            ihl_upd = {vihl_in[3:0], 2'b00};
            ihl_w   = CW'(ihl_upd);
            s       = r - ihl_w;
            if (ihl_upd >= 6'(IP_MIN_HDR) && r >= ihl_w) begin
               if (s <= CW'(L4_OFS_SPORT)) begin
                  sport_in = {sport_ff[7:0], req_chan.data_byte};
               end else if (s <= CW'(L4_OFS_DPORT)) begin
                  dport_in = {dport_ff[7:0], req_chan.data_byte};
               end else if (s <= CW'(L4_OFS_ULEN)) begin
                  ulen_in = {ulen_ff[7:0], req_chan.data_byte};
               end else if (s == CW'(L4_OFS_TCPOFF)) begin
                  toff_in = req_chan.data_byte;
               end
            end
         end
      end
   end

   // Verdict from the state as it stands after this byte
   always_comb begin
      caplen     = CW'(pos_in);
      ihl_n      = {vihl_in[3:0], 2'b00};
      t          = base_w + CW'(ihl_n);
      doff       = {toff_in[7:4], 2'b00};
      ulen_w     = CW'(ulen_in);
      poff       = '0;
      plen       = '0;
      dl         = '0;
      show_ip    = 1'b0;
      show_ports = 1'b0;
      rsp_in.verdict = VERDICT_OTHER;
      if (link_ff == LINK_NONE) begin
         rsp_in.verdict = VERDICT_OTHER;
      end else if (caplen < base_w) begin
         rsp_in.verdict = VERDICT_TRUNC;
      end else if (link_ff == LINK_ETH && etype_in != ETHERTYPE_IPV4) begin
         rsp_in.verdict = VERDICT_NOT_IPV4;
      end else if (caplen < base_w + CW'(IP_MIN_HDR)) begin
         rsp_in.verdict = VERDICT_TRUNC;
      end else if (ihl_n < 6'(IP_MIN_HDR) || vihl_in[7:4] != IP_VERSION_4) begin
         rsp_in.verdict = VERDICT_BAD_IP;
      end else if (proto_in == PROTO_TCP) begin
         if (caplen < t + CW'(TCP_MIN_HDR)) begin
            rsp_in.verdict = VERDICT_TRUNC;
         end else begin
            show_ip    = 1'b1;
            show_ports = 1'b1;
            if (doff < 6'(TCP_MIN_HDR)) begin
               rsp_in.verdict = VERDICT_BAD_TCP;
            end else if (caplen <= t + CW'(doff)) begin
               rsp_in.verdict = VERDICT_EMPTY;
            end else begin
               rsp_in.verdict = VERDICT_TCP;
               poff = t + CW'(doff);
               plen = caplen - poff;
            end
         end
      end else if (proto_in == PROTO_UDP) begin
         if (caplen < t + CW'(UDP_HDR_LEN)) begin
            rsp_in.verdict = VERDICT_TRUNC;
         end else begin
            show_ip    = 1'b1;
            show_ports = 1'b1;
            dl = caplen - t - CW'(UDP_HDR_LEN);
            // Clip to the datagram length field when it is sane
            if (ulen_w >= CW'(UDP_HDR_LEN) && (ulen_w - CW'(UDP_HDR_LEN)) < dl) begin
               dl = ulen_w - CW'(UDP_HDR_LEN);
            end
            if (dl == '0) begin
               rsp_in.verdict = VERDICT_EMPTY;
            end else begin
               rsp_in.verdict = VERDICT_UDP;
               poff = t + CW'(UDP_HDR_LEN);
               plen = dl;
            end
         end
      end else begin
         show_ip        = 1'b1;
         rsp_in.verdict = VERDICT_OTHER;
      end
      rsp_in.protocol       = show_ip ? proto_in : 8'd0;
      rsp_in.src_ip         = show_ip ? sip_in : 32'd0;
      rsp_in.dst_ip         = show_ip ? dip_in : 32'd0;
      rsp_in.src_port       = show_ports ? sport_in : 16'd0;
      rsp_in.dst_port       = show_ports ? dport_in : 16'd0;
      rsp_in.payload_offset = poff[7:0];
      rsp_in.payload_length = (plen[CW-1:16] != '0) ? 16'hFFFF : plen[15:0];
   end

   // Frame state: advance on every byte, clear after the last one
   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff   <= '0;
         etype_ff <= '0;
         vihl_ff  <= '0;
         proto_ff <= '0;
         sip_ff   <= '0;
         dip_ff   <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
         ulen_ff  <= '0;
         toff_ff  <= '0;
      end else if (req_fire) begin
         pos_ff   <= pos_in;
         etype_ff <= etype_in;
         vihl_ff  <= vihl_in;
         proto_ff <= proto_in;
         sip_ff   <= sip_in;
         dip_ff   <= dip_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         ulen_ff  <= ulen_in;
         toff_ff  <= toff_in;
      end
   end

   // Link type register
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= LINK_ETH;
      end else if (csr_chan.valid && csr_chan.ready) begin
         link_ff <= csr_chan.link_type;
      end
   end

   // Output stage: result register backed by a skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (pop) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= push;
         end
      end else if (push) begin
         if (out_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_vld_ff) begin
         out_ff <= skid_ff;
      end else if (push && (pop || !out_vld_ff)) begin
         out_ff <= rsp_in;
      end
      if (push && out_vld_ff && !pop) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.verdict        = out_ff.verdict;
   assign rsp_chan.protocol       = out_ff.protocol;
   assign rsp_chan.src_ip         = out_ff.src_ip;
   assign rsp_chan.dst_ip         = out_ff.dst_ip;
   assign rsp_chan.src_port       = out_ff.src_port;
   assign rsp_chan.dst_port       = out_ff.dst_port;
   assign rsp_chan.payload_offset = out_ff.payload_offset;
   assign rsp_chan.payload_length = out_ff.payload_length;

   // Skid entry only fills behind a held result
   assert property (@(posedge clock) disable iff (reset) skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds a response without the result register");

   // Position saturates at the frame limit
   assert property (@(posedge clock) disable iff (reset) pos_ff <= MAX_POS)
      else $error("frame position beyond limit");

   // A last byte restarts the frame
   assert property (@(posedge clock) disable iff (reset) push |=> pos_ff == '0)
      else $error("frame state not cleared after last byte");

   // A payload verdict always carries a nonempty payload
   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_ff.verdict == VERDICT_TCP || out_ff.verdict == VERDICT_UDP))
         |-> out_ff.payload_length != 16'd0)
      else $error("payload verdict with zero length");

   // Truncated responses carry no ports
   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.verdict == VERDICT_TRUNC)
         |-> (out_ff.src_port == 16'd0 && out_ff.dst_port == 16'd0))
      else $error("truncated verdict with ports");

endmodule
